>>> hw/rtl/kwmh_pkg.sv
// shared types, codes and defaults for the k-way merge min-heap
package kwmh_pkg;

  localparam int SRC_W           = 4;
  localparam int IO_VALUE_W      = 32;
  localparam int COUNT_W         = 5;
  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REPLACE = 2'd1,
    KIND_REMOVE  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_LAST_RD,
    S_LAST_LD,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [IO_VALUE_W-1:0] value;
    logic [SRC_W-1:0]             source;
  } item_t;

  typedef struct packed {
    logic signed [IO_VALUE_W-1:0] top_value;
    logic [SRC_W-1:0]             top_source;
    logic [COUNT_W-1:0]           entry_count;
    logic                         is_empty;
    logic [1:0]                   status;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    set_status;
    status_e status;
    logic    init_ins;
    logic    init_rep;
    logic    init_rem;
    logic    rd_last;
    logic    load_last;
    logic    rd_up;
    logic    rd_dn;
    logic    step_up;
    logic    step_dn;
    logic    finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic one;
    logic up_move;
    logic dn_move;
  } stat_t;

endpackage

>>> hw/rtl/k_way_merge_min_heap.sv
// k-way merge engine: binary min-heap of (value, source) entries with a sequenced sift unit
// refused or unused-kind beats go straight to the strobe and leave the heap alone; each sift
//   level is a ram read, then a compare and write
// throughput: one beat at a time; busy is high from the cycle after start until the strobe,
//   and the next beat may be started in the strobe cycle; the receiver cannot stall results
// reset: rst_ni low clears the entry count and the strobe; heap storage is not cleared
module k_way_merge_min_heap import kwmh_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  // command side: a beat is taken when start is high and busy is low
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  // result side: one beat per command, valid for a single cycle
  output logic    result_valid_o,
  output result_t result_o
);

  // controller and datapath talk only through these two bundles
  cmd_t  cmd;
  stat_t stat;

  // sequencer: decides the operation, walks the sift one level at a time, a read state then a compare state
  kwmh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (item_i.kind),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath: heap ram, the entry being sifted, index math, root shadow, result register
  kwmh_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

>>> hw/rtl/kwmh_ram.sv
// generic single-write, dual-read ram with registered read data
module kwmh_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hw/rtl/kwmh_ctrl.sv
// sequencing state machine for insert, replace-top and remove-top
module kwmh_ctrl import kwmh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] kind_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  ctl_state_e state_q, state_d;
  kind_e      kind;

  assign kind = kind_e'(kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_OK;
          state_d          = S_DONE;
          unique case (kind)
            KIND_INSERT: begin
              if (stat_i.full) begin
                cmd_o.status = STAT_FULL;
              end else begin
                cmd_o.init_ins = 1'b1;
                state_d        = S_UP_RD;
              end
            end
            KIND_REPLACE: begin
              if (stat_i.empty) begin
                cmd_o.status = STAT_EMPTY;
              end else begin
                cmd_o.init_rep = 1'b1;
                state_d        = S_DN_RD;
              end
            end
            KIND_REMOVE: begin
              if (stat_i.empty) begin
                cmd_o.status = STAT_EMPTY;
              end else begin
                cmd_o.init_rem = 1'b1;
                // last entry leaving: nothing to sift
                state_d = stat_i.one ? S_DONE : S_LAST_RD;
              end
            end
            KIND_NONE: begin
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_UP_RD: begin
        cmd_o.rd_up = 1'b1;
        state_d     = S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd_o.step_up = 1'b1;
        state_d       = stat_i.up_move ? S_UP_RD : S_DONE;
      end
      S_DN_RD: begin
        cmd_o.rd_dn = 1'b1;
        state_d     = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.step_dn = 1'b1;
        state_d       = stat_i.dn_move ? S_DN_RD : S_DONE;
      end
      S_LAST_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_LAST_LD;
      end
      S_LAST_LD: begin
        cmd_o.load_last = 1'b1;
        cmd_o.rd_dn     = 1'b1;
        state_d         = S_DN_CMP;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hw/rtl/kwmh_dpath.sv
// heap storage, moving-entry register, index arithmetic and result register
module kwmh_dpath import kwmh_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int EW    = VALUE_WIDTH + SRC_W;
  localparam int IW    = $clog2(CAPACITY);
  localparam int SW    = $clog2(CAPACITY + 1);
  localparam int CW    = SW + 1;
  localparam int EXT_W = (VALUE_WIDTH > IO_VALUE_W) ? VALUE_WIDTH : IO_VALUE_W;

  logic [EW-1:0] cur_q, cur_d;
  logic [EW-1:0] top_q, top_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [SW-1:0] size_q, size_d;
  status_e       status_q, status_d;
  result_t       res_q, res_d;
  logic          res_valid_q;

  logic                          ram_we;
  logic [IW-1:0]                 raddr_a, raddr_b;
  logic [EW-1:0]                 rdata_a, rdata_b, wdata;
  logic signed [VALUE_WIDTH-1:0] in_val, cur_val, a_val, b_val, best_val, top_val;
  logic signed [EXT_W-1:0]       top_ext;
  logic [IW-1:0]                 parent, dn_idx;
  logic [CW-1:0]                 c1, c2, n_ext;
  logic                          c1_ok, c2_ok, less1, less2, up_move, dn_move;
  logic [EW-1:0]                 dn_entry;

  // input value zero-extended or truncated to the stored width
  assign in_val  = VALUE_WIDTH'($unsigned(item_i.value));
  assign cur_val = cur_q[EW-1:SRC_W];
  assign a_val   = rdata_a[EW-1:SRC_W];
  assign b_val   = rdata_b[EW-1:SRC_W];

  assign parent = (idx_q == '0) ? '0 : IW'((idx_q - 1'b1) >> 1);
  assign c1     = CW'({idx_q, 1'b1});
  assign c2     = CW'({idx_q, 1'b0}) + CW'(2);
  assign n_ext  = CW'(size_q);
  assign c1_ok  = (c1 < n_ext);
  assign c2_ok  = (c2 < n_ext);

  // sift-up: move only on strictly less than the parent
  assign up_move = (idx_q != '0) && (cur_val < a_val);

  // sift-down: left child first, right child must beat the better of the two
  assign less1    = c1_ok && (a_val < cur_val);
  assign best_val = less1 ? a_val : cur_val;
  assign less2    = c2_ok && (b_val < best_val);
  assign dn_move  = less1 || less2;
  assign dn_entry = less2 ? rdata_b : rdata_a;
  assign dn_idx   = less2 ? IW'(c2) : IW'(c1);

  always_comb begin
    priority if (cmd_i.rd_last) begin
      raddr_a = IW'(size_q);
    end else if (cmd_i.rd_up) begin
      raddr_a = parent;
    end else begin
      raddr_a = IW'(c1);
    end
  end
  assign raddr_b = IW'(c2);

  assign ram_we = cmd_i.step_up || cmd_i.step_dn;
  always_comb begin
    if (cmd_i.step_up) begin
      wdata = up_move ? rdata_a : cur_q;
    end else begin
      wdata = dn_move ? dn_entry : cur_q;
    end
  end

  kwmh_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (idx_q),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    cur_d    = cur_q;
    idx_d    = idx_q;
    size_d   = size_q;
    top_d    = top_q;
    status_d = status_q;
    if (cmd_i.set_status) begin
      status_d = cmd_i.status;
    end
    if (cmd_i.init_ins) begin
      cur_d  = {in_val, item_i.source};
      idx_d  = IW'(size_q);
      size_d = size_q + 1'b1;
    end
    if (cmd_i.init_rep) begin
      // root keeps its own source tag
      cur_d = {in_val, top_q[SRC_W-1:0]};
      idx_d = '0;
    end
    if (cmd_i.init_rem) begin
      size_d = size_q - 1'b1;
      idx_d  = '0;
    end
    if (cmd_i.load_last) begin
      cur_d = rdata_a;
    end
    if (cmd_i.step_up && up_move) begin
      idx_d = parent;
    end
    if (cmd_i.step_dn && dn_move) begin
      idx_d = dn_idx;
    end
    // shadow copy of the root
    if (ram_we && (idx_q == '0)) begin
      top_d = wdata;
    end
  end

  assign top_val = top_q[EW-1:SRC_W];
  assign top_ext = EXT_W'(top_val);

  always_comb begin
    res_d             = res_q;
    if (cmd_i.finish) begin
      res_d.entry_count = COUNT_W'(size_q);
      res_d.is_empty    = (size_q == '0);
      res_d.status      = status_q;
      res_d.top_value   = (size_q == '0) ? '0 : top_ext[IO_VALUE_W-1:0];
      res_d.top_source  = (size_q == '0) ? '0 : top_q[SRC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      size_q      <= size_d;
      res_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    idx_q    <= idx_d;
    top_q    <= top_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  assign stat_o.full    = (size_q == SW'(CAPACITY));
  assign stat_o.empty   = (size_q == '0);
  assign stat_o.one     = (size_q == SW'(1));
  assign stat_o.up_move = up_move;
  assign stat_o.dn_move = dn_move;

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

>>> hw/rtl/kwmh_checker.sv
// port-level checks for the k-way merge min-heap, bound to the top level
module kwmh_checker import kwmh_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    result_valid_o,
  input result_t result_o
);

  // every accepted beat raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // a result only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without preceding work");

  // busy ends exactly when the result is shown
  a_fall_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  // an empty heap reports zeros and cannot have refused an insert
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.is_empty) |->
      (result_o.entry_count == '0 && result_o.top_value == '0 &&
       result_o.top_source == '0 && result_o.status != STAT_FULL))
    else $error("empty result carries stale fields");

endmodule

bind k_way_merge_min_heap kwmh_checker u_kwmh_checker (.*);

>>> verif/testbench.sv
// self-checking testbench for the k-way merge min-heap: command driver, result monitor, heap predictor
`timescale 1ns / 1ps

module testbench;
  import kwmh_pkg::*;

  localparam int HEAP_CAP = DEF_CAPACITY;

  // clock, reset and block ports; the driven inputs are known from time zero
  logic    clk_i          = 1'b0;
  logic    rst_ni         = 1'b0;
  logic    start          = 1'b0;
  item_t   item_i         = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  // commands still to be presented, and the reports owed by the block in order
  item_t   pending_cmds[$];
  result_t expected_tops[$];

  int n_total   = 0;
  int n_taken   = 0;
  int n_errors  = 0;
  int gen_size  = 0;

  // predictor state: the heap as the block should hold it
  logic signed [IO_VALUE_W-1:0] heap_val [HEAP_CAP];
  logic [SRC_W-1:0]             heap_src [HEAP_CAP];
  int                           heap_cnt = 0;

  k_way_merge_min_heap dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // exchange two heap slots
  function automatic void heap_swap(int a, int b);
    logic signed [IO_VALUE_W-1:0] tv;
    logic [SRC_W-1:0]             ts;
    tv = heap_val[a];
    ts = heap_src[a];
    heap_val[a] = heap_val[b];
    heap_src[a] = heap_src[b];
    heap_val[b] = tv;
    heap_src[b] = ts;
  endfunction

  // push the root down while a child is strictly smaller
  function automatic void heap_sift_down();
    int   idx;
    int   pick;
    logic moving;
    idx    = 0;
    moving = 1'b1;
    while (moving) begin
      pick = idx;
      if (2 * idx + 1 < heap_cnt && heap_val[2 * idx + 1] < heap_val[pick]) pick = 2 * idx + 1;
      if (2 * idx + 2 < heap_cnt && heap_val[2 * idx + 2] < heap_val[pick]) pick = 2 * idx + 2;
      if (pick == idx) begin
        moving = 1'b0;
      end else begin
        heap_swap(pick, idx);
        idx = pick;
      end
    end
  endfunction

  // apply one command to the predicted heap and build the report it should produce
  function automatic result_t heap_apply(item_t cmd);
    result_t r;
    int      idx;
    int      par;
    logic    moving;
    r        = '0;
    r.status = STAT_OK;
    case (cmd.kind)
      KIND_INSERT: begin
        if (heap_cnt >= HEAP_CAP) begin
          r.status = STAT_FULL;
        end else begin
          heap_val[heap_cnt] = cmd.value;
          heap_src[heap_cnt] = cmd.source;
          idx      = heap_cnt;
          heap_cnt = heap_cnt + 1;
          moving   = 1'b1;
          // sift up, moving only past a strictly larger parent
          while (moving && idx > 0) begin
            par = (idx - 1) / 2;
            if (heap_val[idx] < heap_val[par]) begin
              heap_swap(idx, par);
              idx = par;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      KIND_REPLACE: begin
        if (heap_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // root keeps its own source tag
          heap_val[0] = cmd.value;
          heap_sift_down();
        end
      end
      KIND_REMOVE: begin
        if (heap_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          heap_cnt    = heap_cnt - 1;
          heap_val[0] = heap_val[heap_cnt];
          heap_src[0] = heap_src[heap_cnt];
          heap_sift_down();
        end
      end
      default: ;  // unused kind leaves the heap alone
    endcase
    if (heap_cnt == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.top_value  = heap_val[0];
      r.top_source = heap_src[0];
    end
    r.entry_count = heap_cnt[COUNT_W-1:0];
    return r;
  endfunction

  // queue one command and keep a rough count of the heap size in gen_size
  task automatic add_cmd(kind_e k, logic signed [IO_VALUE_W-1:0] v, logic [SRC_W-1:0] s);
    item_t c;
    c.kind   = k;
    c.value  = v;
    c.source = s;
    pending_cmds.push_back(c);
    if (k == KIND_INSERT && gen_size < HEAP_CAP) gen_size++;
    if (k == KIND_REMOVE && gen_size > 0) gen_size--;
  endtask

  // values: mostly full range, a share of small ones so ties happen, and the extremes
  function automatic logic signed [IO_VALUE_W-1:0] rand_value();
    logic signed [IO_VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7fff_ffff;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: v = $signed($urandom_range(0, 15)) - 8;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // command driver: presents the next pending beat, holds it until taken, idles at random
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic hold;
    logic no_gaps;
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else begin
      hold    = start && busy;
      // a long stretch in the middle runs back to back
      no_gaps = n_taken >= 700 && n_taken < 1000;
      if (start && !busy) begin
        expected_tops.push_back(heap_apply(item_i));
        n_taken++;
      end
      if (!hold) begin
        if (pending_cmds.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 32)) begin
          item_i <= pending_cmds.pop_front();
          start  <= 1'b1;
        end else begin
          start  <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobed beat is matched against the oldest prediction
  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_tops.size() == 0) begin
        $error("result beat with nothing expected: top_value %0d", result_o.top_value);
        n_errors++;
      end else begin
        want = expected_tops.pop_front();
        if (result_o.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, result_o.top_value);
          n_errors++;
        end
        if (result_o.top_source !== want.top_source) begin
          $error("top_source: expected %0d, got %0d", want.top_source, result_o.top_source);
          n_errors++;
        end
        if (result_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, result_o.entry_count);
          n_errors++;
        end
        if (result_o.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, result_o.is_empty);
          n_errors++;
        end
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_o.status);
          n_errors++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stim
    int   mode;
    int   roll;
    kind_e k;
    // refused operations on an empty heap and the unused kind
    add_cmd(KIND_REMOVE,  32'sd5, 4'd3);
    add_cmd(KIND_REPLACE, 32'sd9, 4'd7);
    add_cmd(KIND_NONE,    '1,     4'd15);
    // extremes of value and source, a tie with the root that must not move
    add_cmd(KIND_INSERT,  32'sh7fff_ffff, 4'd0);
    add_cmd(KIND_INSERT,  32'sh8000_0000, 4'd15);
    add_cmd(KIND_INSERT,  32'sd0,         4'd5);
    add_cmd(KIND_INSERT,  -32'sd1,        4'd10);
    add_cmd(KIND_INSERT,  32'sh8000_0000, 4'd3);
    // replace ignores the source field and sinks the root
    add_cmd(KIND_REPLACE, 32'sh7fff_ffff, 4'd9);
    add_cmd(KIND_NONE,    32'sh5555_aaaa, 4'd6);
    add_cmd(KIND_REMOVE,  '0,             4'd0);
    // fill to capacity, then one refused insert and a replace on a full heap
    for (int i = 0; i < 12; i++) begin
      add_cmd(KIND_INSERT, (i % 3 == 0) ? -32'sd5 : 32'sd1000 * i - 32'sd6000, i[SRC_W-1:0]);
    end
    add_cmd(KIND_INSERT,  32'sh8000_0000, 4'd1);
    add_cmd(KIND_REPLACE, -32'sd5,        4'd2);

    // random part in phases: filling, draining and steady merging
    mode = 0;
    for (int n = 0; n < 1450; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        k = KIND_NONE;
      end else if (mode == 0) begin
        k = (roll < 70) ? KIND_INSERT : (roll < 88) ? KIND_REPLACE : KIND_REMOVE;
      end else if (mode == 1) begin
        k = (roll < 20) ? KIND_INSERT : (roll < 38) ? KIND_REPLACE : KIND_REMOVE;
      end else begin
        // merge flow: mostly pop-and-refill of the winning source
        k = (roll < 25) ? KIND_INSERT : (roll < 78) ? KIND_REPLACE : KIND_REMOVE;
      end
      add_cmd(k, rand_value(), SRC_W'($urandom_range(0, 15)));
    end
    n_total = pending_cmds.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_taken == n_total);
    wait (expected_tops.size() == 0);
    // room for any stray beat after the last report
    repeat (30) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(4_000_000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
